@@ rtl/core/union_find_rank_halving_unit_defines.svh @@
// Assertion helpers for the union-find unit.
// Each expects clk_i and rst_ni in scope.
`ifndef UNION_FIND_RANK_HALVING_UNIT_DEFINES_SVH
`define UNION_FIND_RANK_HALVING_UNIT_DEFINES_SVH

// Same-cycle implication.
`define UFRH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UFRH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ufrh_pkg.sv @@
`default_nettype none

package ufrh_pkg;

  localparam int unsigned NumElements = 1024;
  localparam int unsigned ElemW       = $clog2(NumElements);
  localparam int unsigned RankW       = 4;

  typedef logic [ElemW-1:0] elem_t;
  typedef logic [RankW-1:0] rank_t;

  localparam elem_t ElemLast = elem_t'(NumElements - 1);
  localparam rank_t RankMax  = '1;

  typedef enum logic {
    OP_FIND  = 1'b0,
    OP_UNION = 1'b1
  } opcode_e;

endpackage

`default_nettype wire

@@ rtl/core/ufrh_if.sv @@
`default_nettype none

// Request channel: one find or union per beat.
interface ufrh_req_if import ufrh_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  opcode;
  elem_t first_element;
  elem_t second_element;

  modport source (output valid, output opcode, output first_element,
                  output second_element, input ready);
  modport sink   (input valid, input opcode, input first_element,
                  input second_element, output ready);
endinterface

// Result channel: one beat per request.
interface ufrh_rsp_if import ufrh_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t root;
  logic  merged;

  modport source (output valid, output root, output merged, input ready);
  modport sink   (input valid, input root, input merged, output ready);
endinterface

`default_nettype wire

@@ rtl/core/union_find_rank_halving_unit.sv @@
// Disjoint-set unit over 1024 elements, union by rank with path halving.
// Parent links and ranks sit in two single-port-read, single-port-write
// memories with registered read data; every step of a walk waits on the
// parent memory read, so the parent read port sets the pace. After reset
// the unit writes every entry as its own root with rank zero and takes no
// request until that is done. A find walks from its element to the root;
// each halving step reads the grandparent, points the current element at
// it and moves there. A union walks from a, then from b, and when the
// roots differ it reads both ranks and links the lower-rank root under
// the other. A stalled result holds the unit in its final state until it
// drains. The result sits in an output register, so the next request is
// taken while it waits.
`default_nettype none

`include "union_find_rank_halving_unit_defines.svh"

module union_find_rank_halving_unit import ufrh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ufrh_req_if.sink   req_i,
  ufrh_rsp_if.source rsp_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLEAR = 7'b0000010,
    ST_F_CHK = 7'b0000100,
    ST_F_WR  = 7'b0001000,
    ST_RK_A  = 7'b0010000,
    ST_RK_B  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  elem_t  clr_q, clr_d;
  logic   out_valid_q, out_valid_d;

  logic   union_q, union_d;
  logic   phase_q, phase_d;
  elem_t  cur_q, cur_d;
  elem_t  sec_q, sec_d;
  elem_t  ra_q, ra_d;
  rank_t  rank_a_q, rank_a_d;
  elem_t  res_root_q, res_root_d;
  logic   res_merged_q, res_merged_d;
  elem_t  root_q, root_d;
  logic   merged_q, merged_d;

  elem_t  parent_mem [NumElements];
  rank_t  rank_mem   [NumElements];
  elem_t  p_rdata_q;
  rank_t  r_rdata_q;
  logic   p_we, r_we;
  elem_t  p_waddr, p_wdata, p_raddr;
  elem_t  r_waddr, r_raddr;
  rank_t  r_wdata;

  elem_t  win_id, lose_id;
  logic   load;

  // lower rank goes under; ties keep the first root
  assign win_id  = (rank_a_q < r_rdata_q) ? cur_q : ra_q;
  assign lose_id = (rank_a_q < r_rdata_q) ? ra_q  : cur_q;

  // rank of ra is fetched as the second walk ends, rank of rb in ST_RK_A
  assign r_raddr = (state_q == ST_RK_A) ? cur_q : ra_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    union_d      = union_q;
    phase_d      = phase_q;
    cur_d        = cur_q;
    sec_d        = sec_q;
    ra_d         = ra_q;
    rank_a_d     = rank_a_q;
    res_root_d   = res_root_q;
    res_merged_d = res_merged_q;
    p_we         = 1'b0;
    p_waddr      = cur_q;
    p_wdata      = p_rdata_q;
    p_raddr      = cur_q;
    r_we         = 1'b0;
    r_waddr      = clr_q;
    r_wdata      = '0;

    unique case (state_q)
      ST_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_q;
        p_wdata = clr_q;
        r_we    = 1'b1;
        r_waddr = clr_q;
        r_wdata = '0;
        clr_d   = clr_q + elem_t'(1);
        if (clr_q == ElemLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          union_d = (req_i.opcode == OP_UNION);
          cur_d   = req_i.first_element;
          sec_d   = req_i.second_element;
          phase_d = 1'b0;
          p_raddr = req_i.first_element;
          state_d = ST_F_CHK;
        end
      end
      ST_F_CHK: begin
        if (p_rdata_q == cur_q) begin
          if (!union_q) begin
            res_root_d   = cur_q;
            res_merged_d = 1'b0;
            state_d      = ST_FIN;
          end else if (!phase_q) begin
            ra_d    = cur_q;
            phase_d = 1'b1;
            cur_d   = sec_q;
            p_raddr = sec_q;
          end else if (ra_q == cur_q) begin
            res_root_d   = ra_q;
            res_merged_d = 1'b0;
            state_d      = ST_FIN;
          end else begin
            state_d = ST_RK_A;
          end
        end else begin
          // fetch the grandparent
          p_raddr = p_rdata_q;
          state_d = ST_F_WR;
        end
      end
      ST_F_WR: begin
        // halve: point cur at its grandparent and move there
        p_we    = 1'b1;
        p_waddr = cur_q;
        p_wdata = p_rdata_q;
        cur_d   = p_rdata_q;
        p_raddr = p_rdata_q;
        state_d = ST_F_CHK;
      end
      ST_RK_A: begin
        rank_a_d = r_rdata_q;
        state_d  = ST_RK_B;
      end
      ST_RK_B: begin
        p_we    = 1'b1;
        p_waddr = lose_id;
        p_wdata = win_id;
        if ((rank_a_q == r_rdata_q) && (rank_a_q != RankMax)) begin
          r_we    = 1'b1;
          r_waddr = ra_q;
          r_wdata = rank_a_q + rank_t'(1);
        end
        res_root_d   = win_id;
        res_merged_d = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign load        = (state_q == ST_FIN) && (!out_valid_q || rsp_o.ready);
  assign out_valid_d = load || (out_valid_q && !rsp_o.ready);
  assign root_d      = load ? res_root_q   : root_q;
  assign merged_d    = load ? res_merged_q : merged_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    union_q      <= union_d;
    phase_q      <= phase_d;
    cur_q        <= cur_d;
    sec_q        <= sec_d;
    ra_q         <= ra_d;
    rank_a_q     <= rank_a_d;
    res_root_q   <= res_root_d;
    res_merged_q <= res_merged_d;
    root_q       <= root_d;
    merged_q     <= merged_d;
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    p_rdata_q <= parent_mem[p_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      rank_mem[r_waddr] <= r_wdata;
    end
    r_rdata_q <= rank_mem[r_raddr];
  end

  assign req_i.ready  = (state_q == ST_IDLE);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.root   = root_q;
  assign rsp_o.merged = merged_q;

  `UFRH_ASSERT_IMPL(a_halve_ports_apart, state_q == ST_F_WR, p_waddr != p_raddr,
                    "halving write collides with next read")
  `UFRH_ASSERT_IMPL(a_rank_bump_tie, r_we && (state_q == ST_RK_B), rank_a_q == r_rdata_q,
                    "rank raised without a tie")
  `UFRH_ASSERT_NEXT(a_clear_steps, (state_q == ST_CLEAR) && (clr_q != ElemLast),
                    clr_q == $past(clr_q) + 1'b1, "clearing pass skipped an entry")
  `UFRH_ASSERT_NEXT(a_result_loaded, load,
                    rsp_o.valid && (rsp_o.root == $past(res_root_q)),
                    "finished result not loaded")

endmodule

`default_nettype wire

@@ sim/ufrh_answer_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels, mirrors the disjoint-set table and checks every answer beat.
module ufrh_answer_checker import ufrh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ufrh_req_if         req_i,
  ufrh_rsp_if         rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  typedef struct packed {
    opcode_e op;
    elem_t   first_elem;
    elem_t   second_elem;
    elem_t   root;
    logic    merged;
  } answer_t;

  elem_t   link_table [NumElements];
  rank_t   rank_table [NumElements];
  answer_t answer_q [$];

  function automatic bit in_table(elem_t e);
    return int'(e) < int'(NumElements);
  endfunction

  // Walk to the root, pointing each visited entry at its grandparent.
  function automatic elem_t halve_to_root(elem_t e);
    elem_t cur;
    elem_t up;
    cur = e;
    while (link_table[cur] != cur) begin
      up              = link_table[cur];
      link_table[cur] = link_table[up];
      cur             = link_table[cur];
    end
    return cur;
  endfunction

  function automatic answer_t predict_answer(opcode_e op, elem_t a, elem_t b);
    answer_t ans;
    elem_t   ra;
    elem_t   rb;
    elem_t   winner;
    elem_t   loser;
    ans.op          = op;
    ans.first_elem  = a;
    ans.second_elem = b;
    ans.merged      = 1'b0;
    if (op == OP_FIND) begin
      ans.root = in_table(a) ? halve_to_root(a) : a;
    end else if (!in_table(a)) begin
      ans.root = a;
    end else begin
      ra       = halve_to_root(a);
      ans.root = ra;
      if (in_table(b)) begin
        rb = halve_to_root(b);
        if (ra != rb) begin
          winner = ra;
          loser  = rb;
          if (rank_table[ra] < rank_table[rb]) begin
            winner = rb;
            loser  = ra;
          end
          link_table[loser] = winner;
          if (rank_table[winner] == rank_table[loser] && rank_table[winner] < RankMax)
            rank_table[winner] = rank_table[winner] + 1'b1;
          ans.root   = winner;
          ans.merged = 1'b1;
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    answer_t exp_ans;
    if (!rst_ni) begin
      for (int k = 0; k < int'(NumElements); k++) begin
        link_table[k] = elem_t'(k);
        rank_table[k] = '0;
      end
      answer_q.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (answer_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: answer beat with none outstanding: root=%0d merged=%0b",
                     $realtime, rsp_i.root, rsp_i.merged);
        end else begin
          exp_ans = answer_q.pop_front();
          if (rsp_i.root !== exp_ans.root || rsp_i.merged !== exp_ans.merged) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("%0t: %s a=%0d b=%0d: expected root=%0d merged=%0b, got root=%0d merged=%0b",
                       $realtime, exp_ans.op.name(), exp_ans.first_elem, exp_ans.second_elem,
                       exp_ans.root, exp_ans.merged, rsp_i.root, rsp_i.merged);
          end
        end
      end
      if (req_i.valid && req_i.ready)
        answer_q.push_back(predict_answer(opcode_e'(req_i.opcode), req_i.first_element,
                                          req_i.second_element));
      pending_count_o = answer_q.size();
    end
  end

endmodule

@@ sim/union_find_rank_halving_unit_test.sv @@
`timescale 1ns / 100ps

module union_find_rank_halving_unit_test;
  import ufrh_pkg::*;

  typedef struct {
    int base;
    int span;
  } block_t;

  logic        clk;
  logic        rst_n;
  bit          calm_tail;
  int unsigned items_sent;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int          next_fresh;
  int          rsp_stall_left;
  block_t      built_blocks [$];

  ufrh_req_if req_ch ();
  ufrh_rsp_if rsp_ch ();

  union_find_rank_halving_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  ufrh_answer_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .req_i            (req_ch),
    .rsp_i            (rsp_ch),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL union_find_rank_halving_unit");
    $finish;
  end

  // Answer side back-pressure: random stall bursts, none in the tail.
  initial begin
    rsp_ch.ready   <= 1'b0;
    rsp_stall_left = 0;
    forever begin
      @(posedge clk);
      if (calm_tail) begin
        rsp_ch.ready <= 1'b1;
      end else if (rsp_stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        rsp_ch.ready   <= 1'b0;
        rsp_stall_left = $urandom_range(0, 3);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Called at a clock edge; returns at the edge where the beat is taken.
  task automatic send_request(opcode_e op, elem_t a, elem_t b);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.opcode         <= op;
    req_ch.first_element  <= a;
    req_ch.second_element <= b;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Pairwise merges of fresh singletons give a binomial tree of depth log2(span).
  task automatic build_tree(int base, int span);
    for (int step = 1; step < span; step = step * 2)
      for (int i = 0; i < span; i += 2 * step)
        send_request(OP_UNION, elem_t'(base + i), elem_t'(base + i + step));
  endtask

  initial begin : stimulus
    int     r;
    int     span;
    int     base;
    elem_t  a;
    block_t blk_a;
    block_t blk_b;

    req_ch.valid          <= 1'b0;
    req_ch.opcode         <= OP_FIND;
    req_ch.first_element  <= '0;
    req_ch.second_element <= '0;
    rst_n                 <= 1'b0;
    calm_tail  = 1'b0;
    items_sent = 0;
    next_fresh = 16;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: table ends, same-set unions, equal-rank links, halving walks.
    send_request(OP_FIND,  '0, '0);
    send_request(OP_FIND,  ElemLast, '1);
    send_request(OP_UNION, '0, ElemLast);
    send_request(OP_UNION, ElemLast, '0);
    send_request(OP_FIND,  ElemLast, '0);
    send_request(OP_UNION, elem_t'(3), elem_t'(3));
    send_request(OP_FIND,  elem_t'(7), '1);
    send_request(OP_UNION, elem_t'(1), elem_t'(2));
    send_request(OP_UNION, elem_t'(2), elem_t'(1));
    send_request(OP_UNION, elem_t'(1), '0);
    send_request(OP_FIND,  ElemLast, elem_t'(10'h155));
    send_request(OP_FIND,  ElemLast, elem_t'(10'h2aa));
    send_request(OP_UNION, elem_t'(4), elem_t'(5));
    send_request(OP_UNION, elem_t'(4), ElemLast);
    send_request(OP_UNION, elem_t'(10'h155), elem_t'(10'h2aa));
    send_request(OP_UNION, elem_t'(10'h2aa), elem_t'(6));
    send_request(OP_FIND,  elem_t'(10'h155), '1);
    send_request(OP_UNION, elem_t'(512), elem_t'(511));
    send_request(OP_FIND,  elem_t'(2), '0);
    send_request(OP_FIND,  elem_t'(5), '0);

    while (items_sent < 500) begin
      calm_tail = (items_sent >= 440);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        span = 1 << $urandom_range(2, 5);
        if (next_fresh + span <= int'(NumElements)) begin
          base       = next_fresh;
          next_fresh = next_fresh + span;
        end else begin
          base = $urandom_range(0, int'(NumElements) / span - 1) * span;
        end
        build_tree(base, span);
        send_request(OP_FIND, elem_t'(base + span - 1), elem_t'($urandom));
        built_blocks.push_back('{base, span});
      end else if (r < 25 && built_blocks.size() >= 2) begin
        // Join two built trees so the leaves sit deeper still.
        blk_a = built_blocks.pop_front();
        blk_b = built_blocks.pop_front();
        send_request(OP_UNION, elem_t'(blk_a.base), elem_t'(blk_b.base));
        send_request(OP_FIND, elem_t'(blk_b.base + blk_b.span - 1), elem_t'($urandom));
        send_request(OP_FIND, elem_t'(blk_a.base + blk_a.span - 1), elem_t'($urandom));
      end else if (r < 50) begin
        a = elem_t'($urandom);
        send_request(OP_UNION, a, a ^ elem_t'($urandom_range(0, 15)));
      end else if (r < 65) begin
        send_request(OP_UNION, elem_t'($urandom), elem_t'($urandom));
      end else begin
        send_request(OP_FIND, elem_t'($urandom), elem_t'($urandom));
      end
    end
    req_ch.valid <= 1'b0;

    wait (pending_count == 0);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASS union_find_rank_halving_unit");
    end else begin
      $display("FAIL union_find_rank_halving_unit");
    end
    $finish;
  end

endmodule
